// ===== sv/vld_pkg.sv =====
// Shared types and constants for the varint length deframer.
// No dependencies; imported by the deframer and its port checker.
`default_nettype none

package vld_pkg;

	localparam int unsigned MAX_HEADER_BYTES = 5;
	localparam int unsigned HDR_CNT_W        = 3;
	localparam int unsigned LEN_W            = 32;
	localparam int unsigned BYTE_W           = 8;
	localparam int unsigned PAYLOAD_W        = 7;
	localparam int unsigned MORE_BIT         = 7;
	localparam int unsigned KIND_W           = 2;
	localparam int unsigned RES_TDATA_W      = BYTE_W + LEN_W;

	localparam logic [LEN_W-1:0] MAX_BODY_RESET = 32'd65536;

	localparam logic [KIND_W-1:0] KIND_BODY      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVERSIZE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_MALFORMED = 2'd3;

	typedef struct packed {
		logic [LEN_W-1:0]  frame_length;
		logic [BYTE_W-1:0] out_byte;
		logic [KIND_W-1:0] kind;
		logic              frame_last;
	} vld_res_t;

endpackage

`default_nettype wire

// ===== sv/varint_length_deframer.sv =====
// Varint length-prefixed stream deframer: top level.
// Depends on vld_pkg for kind codes, widths and the result type.
//
// Splits a byte stream into frames, each led by a little-endian base-128
// varint length header of up to five bytes (bit 7 set means another header
// byte follows; payload bits above bit 31 are dropped). After a nonzero
// header that many body bytes pass through with kind BODY, the last one with
// tlast set. A zero length gives one EMPTY word, a length above
// max_body_length one OVERSIZE word carrying the rejected length, and a fifth
// header byte that still has its continuation bit set gives one MALFORMED
// word; in every one of those cases the next byte starts a fresh header.
// Header bytes otherwise produce nothing. Throughput is one byte per clock
// while the skid entry is empty: each byte is decoded by a single pass of
// logic at the input handshake and its result is written at that same edge
// into the main output register, or into the skid entry if the main one is
// held. The skid entry lets the block keep taking bytes after the downstream
// side stalls, until it fills; s_axis_tready comes from a register and never
// depends combinationally on m_axis_tready. max_body_length is written
// through the cfg channel, which is always ready; write it only while idle.
`default_nettype none

module varint_length_deframer
	import vld_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration: max_body_length
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [LEN_W-1:0]       cfg_data,
	// input stream
	input  wire logic                   s_axis_tvalid,
	output      logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] in_byte
	// result stream
	output      logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output      logic [RES_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [39:8] frame_length
	output      logic [KIND_W-1:0]      m_axis_tuser,   // [1:0] kind
	output      logic                   m_axis_tlast    // frame_last
);

	// decoder state
	logic [LEN_W-1:0]     max_len_q;
	logic                 in_body_q;
	logic [LEN_W-1:0]     accum_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [LEN_W-1:0]     remaining_q;
	logic [LEN_W-1:0]     declared_q;

	// output buffer: main entry and skid entry
	logic     out_vld_q;
	logic     skid_vld_q;
	vld_res_t out_q;
	vld_res_t skid_q;

	logic                 accept;
	logic                 res_vld;
	vld_res_t             res;
	logic [LEN_W-1:0]     part;
	logic [LEN_W-1:0]     len_new;
	logic [HDR_CNT_W-1:0] cnt_next;
	logic                 more;
	logic                 body_last;
	logic                 main_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !skid_vld_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign main_free     = !out_vld_q || m_axis_tready;

	assign more      = s_axis_tdata[MORE_BIT];
	assign cnt_next  = hdr_cnt_q + HDR_CNT_W'(1);
	assign body_last = (remaining_q <= LEN_W'(1));

	// place the 7 payload bits at 7 * header position; bits past 31 drop
	always_comb begin
		part = '0;
		if (hdr_cnt_q < HDR_CNT_W'(MAX_HEADER_BYTES)) begin
			part = LEN_W'(s_axis_tdata[PAYLOAD_W-1:0]) << (6'(hdr_cnt_q) * 6'(PAYLOAD_W));
		end
	end
	assign len_new = accum_q | part;

	// result of the current byte, if it makes one
	always_comb begin
		res_vld          = 1'b0;
		res.out_byte     = '0;
		res.kind         = KIND_BODY;
		res.frame_last   = 1'b1;
		res.frame_length = '0;
		priority if (in_body_q) begin
			res_vld          = 1'b1;
			res.out_byte     = s_axis_tdata;
			res.frame_last   = body_last;
			res.frame_length = declared_q;
		end else if (more) begin
			if (cnt_next >= HDR_CNT_W'(MAX_HEADER_BYTES)) begin
				res_vld  = 1'b1;
				res.kind = KIND_MALFORMED;
			end
		end else if (len_new > max_len_q) begin
			res_vld          = 1'b1;
			res.kind         = KIND_OVERSIZE;
			res.frame_length = len_new;
		end else if (len_new == '0) begin
			res_vld  = 1'b1;
			res.kind = KIND_EMPTY;
		end else begin
			// accepted nonzero length: the body follows, no word yet
			res_vld = 1'b0;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_BODY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// header / body state, advanced once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q   <= 1'b0;
			accum_q     <= '0;
			hdr_cnt_q   <= '0;
			remaining_q <= '0;
			declared_q  <= '0;
		end else if (accept) begin
			priority if (in_body_q) begin
				if (body_last) begin
					in_body_q   <= 1'b0;
					remaining_q <= '0;
				end else begin
					remaining_q <= remaining_q - LEN_W'(1);
				end
			end else if (more) begin
				// drop a header that runs past the last allowed byte
				if (cnt_next >= HDR_CNT_W'(MAX_HEADER_BYTES)) begin
					accum_q   <= '0;
					hdr_cnt_q <= '0;
				end else begin
					accum_q   <= len_new;
					hdr_cnt_q <= cnt_next;
				end
			end else begin
				accum_q   <= '0;
				hdr_cnt_q <= '0;
				if (len_new <= max_len_q && len_new != '0) begin
					in_body_q   <= 1'b1;
					remaining_q <= len_new;
					declared_q  <= len_new;
				end
			end
		end
	end

	// output buffer control: the skid entry fills only while main is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (main_free) begin
			out_vld_q  <= skid_vld_q || (accept && res_vld);
			skid_vld_q <= 1'b0;
		end else if (accept && res_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (accept && res_vld) begin
				out_q <= res;
			end
		end else if (accept && res_vld) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q.frame_length, out_q.out_byte};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.frame_last;

endmodule

`default_nettype wire

// ===== sv/vld_checker.sv =====
// Port-level checker for varint_length_deframer, bound to the top level.
// Depends on vld_pkg for kind codes and widths.
`default_nettype none

module vld_checker
	import vld_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [RES_TDATA_W-1:0] m_axis_tdata,
	input wire logic [KIND_W-1:0]      m_axis_tuser,
	input wire logic                   m_axis_tlast
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// every non-body word closes its frame
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_BODY |-> m_axis_tlast)
		else $error("non-body word without tlast");

	// empty and malformed words carry no byte and no length
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_EMPTY || m_axis_tuser == KIND_MALFORMED)
			|-> m_axis_tdata == '0)
		else $error("empty or malformed word with nonzero data");

	// oversize word carries the rejected length, which cannot be zero
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_OVERSIZE
			|-> m_axis_tdata[BYTE_W-1:0] == '0 && m_axis_tdata[RES_TDATA_W-1:BYTE_W] != '0)
		else $error("malformed oversize word");

endmodule

bind varint_length_deframer vld_checker u_vld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
